### hdl/ddmw_pkg.sv
package ddmw_pkg;

  localparam logic [1:0] ACT_DRIVE = 2'd0;
  localparam logic [1:0] ACT_DOME  = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  localparam int unsigned SpeedLimit  = 100;
  localparam int unsigned DutyFull    = 255;
  // 255 * ceil(2^19 / 100): floor(mag * 255 / 100) == (mag * DutyRecip) >> 19 for mag <= 100
  localparam int unsigned DutyRecip   = 1336965;
  localparam int unsigned DutyShift   = 19;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [15:0] IDLE_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
    logic signed [7:0] dome_speed;
  } in_word_t;

  typedef struct packed {
    logic       left_reverse;
    logic [7:0] left_duty;
    logic       right_reverse;
    logic [7:0] right_duty;
    logic       dome_reverse;
    logic [7:0] dome_duty;
    logic       any_active;
    logic       timed_out;
  } out_word_t;

  typedef struct packed {
    logic       reverse;
    logic [7:0] duty;
    logic       nonzero;
  } motor_t;

  // clamp a 9-bit signed speed to +-100 and turn it into direction and duty
  function automatic motor_t speed_to_motor(logic signed [8:0] s);
    logic signed [8:0] lim;
    logic [6:0]        mag;
    logic [27:0]       prod;
    motor_t            m;
    lim = s;
    if (s > 9'sd100) begin
      lim = 9'sd100;
    end else if (s < -9'sd100) begin
      lim = -9'sd100;
    end
    mag       = lim[8] ? 7'(-lim) : 7'(lim);
    prod      = 28'(mag) * 28'(DutyRecip);
    m.reverse = lim[8];
    m.duty    = prod[DutyShift+7:DutyShift];
    m.nonzero = (mag != 7'd0);
    return m;
  endfunction

endpackage

### hdl/differential_drive_mixer_watchdog_core.sv
// channel  direction  valid       stall        payload
// in       input      in_valid_i  in_stall_o   in_word_i  (ddmw_pkg::in_word_t)
// out      output     out_valid_o out_stall_i  out_word_o (ddmw_pkg::out_word_t)
// cfg      input      cfg_we_i    -            cfg_wdata_i (timeout_ms)
//
// one word per cycle while in_stall_o is low; its result shows in the cycle after acceptance
// the result register is the only stage and also holds the motor state
// in_stall_o is high only while a result is held and out_stall_i is high
// reset clears all motor state and the idle counter, timeout_ms goes to 500
module differential_drive_mixer_watchdog_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ddmw_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ddmw_pkg::out_word_t  out_word_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);
  import ddmw_pkg::*;

  logic        out_valid_q;
  logic [15:0] timeout_q;
  logic [15:0] idle_q, idle_d;
  motor_t      left_q, left_d, right_q, right_d, dome_q, dome_d;
  logic        drive_on_q, drive_on_d, dome_on_q, dome_on_d;
  logic        fired_q, fired_d;
  logic        in_acc;
  logic [15:0] idle_inc;
  motor_t      left_m, right_m, dome_m;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign left_m  = speed_to_motor(9'(in_word_i.stick_y) + 9'(in_word_i.stick_x));
  assign right_m = speed_to_motor(9'(in_word_i.stick_y) - 9'(in_word_i.stick_x));
  assign dome_m  = speed_to_motor(9'(in_word_i.dome_speed));
  assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;

  always_comb begin
    left_d     = left_q;
    right_d    = right_q;
    dome_d     = dome_q;
    drive_on_d = drive_on_q;
    dome_on_d  = dome_on_q;
    idle_d     = idle_q;
    fired_d    = 1'b0;
    case (in_word_i.action)
      ACT_DRIVE: begin
        left_d     = left_m;
        right_d    = right_m;
        drive_on_d = left_m.nonzero || right_m.nonzero;
        idle_d     = '0;
      end
      ACT_DOME: begin
        dome_d    = dome_m;
        dome_on_d = dome_m.nonzero;
        idle_d    = '0;
      end
      ACT_STOP: begin
        left_d     = '0;
        right_d    = '0;
        dome_d     = '0;
        drive_on_d = 1'b0;
        dome_on_d  = 1'b0;
      end
      ACT_TICK: begin
        idle_d = idle_inc;
        // increment first, then compare against the timeout
        if ((drive_on_q || dome_on_q) && idle_inc >= timeout_q) begin
          left_d     = '0;
          right_d    = '0;
          dome_d     = '0;
          drive_on_d = 1'b0;
          dome_on_d  = 1'b0;
          fired_d    = 1'b1;
        end
      end
      default: begin
        idle_d = idle_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      timeout_q   <= TIMEOUT_RST;
      idle_q      <= '0;
      left_q      <= '0;
      right_q     <= '0;
      dome_q      <= '0;
      drive_on_q  <= 1'b0;
      dome_on_q   <= 1'b0;
      fired_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
        idle_q      <= idle_d;
        left_q      <= left_d;
        right_q     <= right_d;
        dome_q      <= dome_d;
        drive_on_q  <= drive_on_d;
        dome_on_q   <= dome_on_d;
        fired_q     <= fired_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // the result word mirrors the state left by the last accepted word
  assign out_valid_o              = out_valid_q;
  assign out_word_o.left_reverse  = left_q.reverse;
  assign out_word_o.left_duty     = left_q.duty;
  assign out_word_o.right_reverse = right_q.reverse;
  assign out_word_o.right_duty    = right_q.duty;
  assign out_word_o.dome_reverse  = dome_q.reverse;
  assign out_word_o.dome_duty     = dome_q.duty;
  assign out_word_o.any_active    = drive_on_q || dome_on_q;
  assign out_word_o.timed_out     = fired_q;

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.action == ACT_STOP |=>
      !out_word_o.any_active && out_word_o.left_duty == 8'd0 &&
      out_word_o.right_duty == 8'd0 && out_word_o.dome_duty == 8'd0)
    else $error("stop left a channel running");

  a_cmd_clears_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_word_i.action == ACT_DRIVE || in_word_i.action == ACT_DOME) |=>
      idle_q == 16'd0)
    else $error("command did not clear idle counter");

  a_fire_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fired_q |->
      !drive_on_q && !dome_on_q && left_q.duty == 8'd0 &&
      right_q.duty == 8'd0 && dome_q.duty == 8'd0)
    else $error("timeout did not stop all channels");

  a_fire_needs_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.action != ACT_TICK |=> !fired_q)
    else $error("timeout flagged on a non-tick word");

endmodule
